// ===== hw/rtl/mi4_pkg.sv =====
// ----------------------------------------------------------------------------
// mi4_pkg: shared definitions for the 4x4 matrix inverse
// Widths, the control word and the microprogram of the cofactor sequencer.
// ----------------------------------------------------------------------------
package mi4_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ELEM_W    = 32;
  localparam int IDX_W     = 4;
  localparam int TDATA_W   = 40;
  localparam int LIMB_W    = 32;
  localparam int NUM_LIMBS = 4;
  localparam int LIMB_CW   = 2;
  localparam int SCR_W     = LIMB_W * NUM_LIMBS;
  localparam int PROD_W    = LIMB_W + 1 + ELEM_W;
  localparam int COF_W     = 97;
  localparam int DET_W     = 130;
  localparam int ACC_W     = DET_W;
  localparam int DEN_W     = DET_W + 1;
  localparam int QW        = 34;
  localparam int QCNT_W    = 6;
  localparam int DSH       = 2 * FRAC_BITS + 1;
  localparam int NUM_W     = ((COF_W + DSH > DET_W) ? COF_W + DSH : DET_W) + 1;
  localparam int DIV_W     = (NUM_W > DEN_W + QW - 1) ? NUM_W : DEN_W + QW - 1;
  localparam int SCR_DEPTH = 40;
  localparam int SCR_AW    = 6;
  localparam int STEP_W    = 8;

  localparam int ST_COF   = 24;
  localparam int ST_DET   = 120;
  localparam int ST_JZ    = 124;
  localparam int ST_DIV   = 125;
  localparam int ST_RAW   = 141;
  localparam int COF_BASE = 24;

  localparam logic [IDX_W-1:0]  IDX_LAST = 4'd15;
  localparam logic [ELEM_W-1:0] VAL_MAX  = 32'h7FFF_FFFF;
  localparam logic [ELEM_W-1:0] VAL_MIN  = 32'h8000_0000;

  typedef enum logic [1:0] {OP_MAC, OP_JZ, OP_DIV, OP_RAW} op_t;

  typedef enum logic [2:0] {S_IDLE, S_RDA, S_RDB, S_MUL, S_TAIL, S_DIV, S_OUT} st_t;

  typedef enum logic [1:0] {DV_IDLE, DV_PREP, DV_RUN} dv_st_t;

  typedef struct packed {
    op_t                op;
    logic               a_elem;
    logic [SCR_AW-1:0]  a_addr;
    logic [IDX_W-1:0]   ea;
    logic [IDX_W-1:0]   eb;
    logic [LIMB_CW-1:0] nl;
    logic               clr;
    logic               sub;
    logic               wr;
    logic               wr_det;
    logic [SCR_AW-1:0]  dst;
    logic [IDX_W-1:0]   k;
    logic               last;
    logic [STEP_W-1:0]  target;
    logic               done;
  } cw_t;

  typedef struct packed {
    logic               load;
    logic               clr;
    logic               mul;
    logic               top;
    logic               sub;
    logic [LIMB_CW-1:0] limb;
  } mac_ctl_t;

  localparam logic [3:0] PAIR_TAB [12][2] = '{
    '{4'd10, 4'd15}, '{4'd11, 4'd14}, '{4'd9, 4'd15}, '{4'd11, 4'd13},
    '{4'd9, 4'd14},  '{4'd10, 4'd13}, '{4'd8, 4'd15}, '{4'd11, 4'd12},
    '{4'd8, 4'd14},  '{4'd10, 4'd12}, '{4'd8, 4'd13}, '{4'd9, 4'd12}
  };

  localparam logic [3:0] COF_TAB [16][12] = '{
    '{4'd0, 4'd5, 4'd3, 4'd6, 4'd4, 4'd7, 4'd1, 4'd5, 4'd2, 4'd6, 4'd5, 4'd7},
    '{4'd1, 4'd4, 4'd6, 4'd6, 4'd9, 4'd7, 4'd0, 4'd4, 4'd7, 4'd6, 4'd8, 4'd7},
    '{4'd2, 4'd4, 4'd7, 4'd5, 4'd10, 4'd7, 4'd3, 4'd4, 4'd6, 4'd5, 4'd11, 4'd7},
    '{4'd5, 4'd4, 4'd8, 4'd5, 4'd11, 4'd6, 4'd4, 4'd4, 4'd9, 4'd5, 4'd10, 4'd6},
    '{4'd1, 4'd1, 4'd2, 4'd2, 4'd5, 4'd3, 4'd0, 4'd1, 4'd3, 4'd2, 4'd4, 4'd3},
    '{4'd0, 4'd0, 4'd7, 4'd2, 4'd8, 4'd3, 4'd1, 4'd0, 4'd6, 4'd2, 4'd9, 4'd3},
    '{4'd3, 4'd0, 4'd6, 4'd1, 4'd11, 4'd3, 4'd2, 4'd0, 4'd7, 4'd1, 4'd10, 4'd3},
    '{4'd4, 4'd0, 4'd9, 4'd1, 4'd10, 4'd2, 4'd5, 4'd0, 4'd8, 4'd1, 4'd11, 4'd2},
    '{4'd0, 4'd13, 4'd3, 4'd14, 4'd4, 4'd15, 4'd1, 4'd13, 4'd2, 4'd14, 4'd5, 4'd15},
    '{4'd1, 4'd12, 4'd6, 4'd14, 4'd9, 4'd15, 4'd0, 4'd12, 4'd7, 4'd14, 4'd8, 4'd15},
    '{4'd2, 4'd12, 4'd7, 4'd13, 4'd10, 4'd15, 4'd3, 4'd12, 4'd6, 4'd13, 4'd11, 4'd15},
    '{4'd5, 4'd12, 4'd8, 4'd13, 4'd11, 4'd14, 4'd4, 4'd12, 4'd9, 4'd13, 4'd10, 4'd14},
    '{4'd2, 4'd10, 4'd5, 4'd11, 4'd1, 4'd9, 4'd4, 4'd11, 4'd0, 4'd9, 4'd3, 4'd10},
    '{4'd8, 4'd11, 4'd0, 4'd8, 4'd7, 4'd10, 4'd6, 4'd10, 4'd9, 4'd11, 4'd1, 4'd8},
    '{4'd6, 4'd9, 4'd11, 4'd11, 4'd3, 4'd8, 4'd10, 4'd11, 4'd2, 4'd8, 4'd7, 4'd9},
    '{4'd10, 4'd10, 4'd4, 4'd8, 4'd9, 4'd9, 4'd8, 4'd9, 4'd11, 4'd10, 4'd5, 4'd8}
  };

  // Position of transposed element j in the row-major store.
  function automatic logic [IDX_W-1:0] src_addr(input logic [IDX_W-1:0] j);
    return {j[1:0], j[3:2]};
  endfunction

  function automatic cw_t ucode(input logic [STEP_W-1:0] step);
    cw_t cw;
    int  s;
    int  r;
    int  h;
    int  i;
    int  c;
    int  t;
    cw = '0;
    s  = int'(step);
    if (s < ST_COF) begin
      h         = (s >= 12) ? 1 : 0;
      i         = s - 12 * h;
      cw.op     = OP_MAC;
      cw.a_elem = 1'b1;
      cw.ea     = src_addr(IDX_W'(int'(PAIR_TAB[i][0]) - 8 * h));
      cw.eb     = src_addr(IDX_W'(int'(PAIR_TAB[i][1]) - 8 * h));
      cw.clr    = 1'b1;
      cw.wr     = 1'b1;
      cw.dst    = SCR_AW'(s);
    end else if (s < ST_DET) begin
      r = s - ST_COF;
      c = 0;
      for (int n = 1; n < 16; n++) begin
        if (r >= 6 * n) c = n;
      end
      t         = r - 6 * c;
      cw.op     = OP_MAC;
      cw.a_addr = SCR_AW'(((c >= 8) ? 12 : 0) + int'(COF_TAB[c][2 * t]));
      cw.eb     = src_addr(COF_TAB[c][2 * t + 1]);
      cw.nl     = LIMB_CW'(1);
      cw.clr    = (t == 0);
      cw.sub    = (t >= 3);
      cw.wr     = (t == 5);
      cw.dst    = SCR_AW'(COF_BASE + c);
    end else if (s < ST_JZ) begin
      i         = s - ST_DET;
      cw.op     = OP_MAC;
      cw.a_addr = SCR_AW'(COF_BASE + i);
      cw.eb     = src_addr(IDX_W'(i));
      cw.nl     = LIMB_CW'(NUM_LIMBS - 1);
      cw.clr    = (i == 0);
      cw.wr_det = (i == 3);
    end else if (s == ST_JZ) begin
      cw.op     = OP_JZ;
      cw.target = STEP_W'(ST_RAW);
    end else if (s < ST_RAW) begin
      i         = s - ST_DIV;
      cw.op     = OP_DIV;
      cw.a_addr = SCR_AW'(COF_BASE + i);
      cw.k      = IDX_W'(i);
      cw.last   = (i == 15);
      cw.done   = (i == 15);
    end else if (s < ST_RAW + 16) begin
      i       = s - ST_RAW;
      cw.op   = OP_RAW;
      cw.ea   = IDX_W'(i);
      cw.k    = IDX_W'(i);
      cw.last = (i == 15);
      cw.done = (i == 15);
    end else begin
      cw.op   = OP_JZ;
      cw.done = 1'b1;
    end
    return cw;
  endfunction

endpackage

// ===== hw/rtl/mi4_mac.sv =====
// ----------------------------------------------------------------------------
// mi4_mac: limb-serial multiply-accumulate
// Multiplies a wide signed operand by a 32-bit element one limb per cycle and
// accumulates the shifted partial products into a wide accumulator.
// ----------------------------------------------------------------------------
module mi4_mac (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mi4_pkg::mac_ctl_t                  ctl,
  input  logic [mi4_pkg::SCR_W-1:0]          a_val,
  input  logic signed [mi4_pkg::ELEM_W-1:0]  b_val,
  output logic [mi4_pkg::ACC_W-1:0]          acc_nxt
);

  logic [mi4_pkg::SCR_W-1:0]         opa_r;
  logic signed [mi4_pkg::PROD_W-1:0] prod_r;
  logic                              pv_r;
  logic [mi4_pkg::LIMB_CW-1:0]       sh_r;
  logic                              sub_r;
  logic [mi4_pkg::ACC_W-1:0]         acc_r;

  logic [mi4_pkg::LIMB_W-1:0]        limb_bits;
  logic signed [mi4_pkg::LIMB_W:0]   a_ext;
  logic signed [mi4_pkg::PROD_W-1:0] prod;
  logic [mi4_pkg::ACC_W-1:0]         term;

  assign limb_bits = opa_r[ctl.limb * mi4_pkg::LIMB_W +: mi4_pkg::LIMB_W];
  assign a_ext     = {ctl.top & limb_bits[mi4_pkg::LIMB_W-1], limb_bits};
  assign prod      = a_ext * b_val;
  assign term      = {{(mi4_pkg::ACC_W - mi4_pkg::PROD_W){prod_r[mi4_pkg::PROD_W-1]}}, prod_r}
                     << (32'(sh_r) * mi4_pkg::LIMB_W);

  always_comb begin
    if (ctl.clr) begin
      acc_nxt = '0;
    end else if (pv_r) begin
      acc_nxt = sub_r ? acc_r - term : acc_r + term;
    end else begin
      acc_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= ctl.mul;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) opa_r <= a_val;
    if (ctl.mul) begin
      prod_r <= prod;
      sh_r   <= ctl.limb;
      sub_r  <= ctl.sub;
    end
    acc_r <= acc_nxt;
  end

endmodule

// ===== hw/rtl/mi4_div.sv =====
// ----------------------------------------------------------------------------
// mi4_div: rounding cofactor divider
// Forms the rounded quotient |cof| * 2^(2F) / |det| by restoring division,
// one quotient bit per cycle; range checks on the 34-bit quotient are made by the sequencer.
// ----------------------------------------------------------------------------
module mi4_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [mi4_pkg::COF_W-1:0]  cof,
  input  logic [mi4_pkg::DET_W-1:0]         den_abs,
  output logic                              done,
  output logic [mi4_pkg::QW-1:0]            q
);

  mi4_pkg::dv_st_t              st_r, st_nxt;
  logic [mi4_pkg::COF_W-1:0]    mag_r, mag_nxt;
  logic [mi4_pkg::DET_W-1:0]    den_r, den_nxt;
  logic [mi4_pkg::DIV_W-1:0]    rem_r, rem_nxt;
  logic [mi4_pkg::DIV_W-1:0]    d_r, d_nxt;
  logic [mi4_pkg::QW-1:0]       q_r, q_nxt;
  logic [mi4_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         done_r, done_nxt;
  logic                         ge;

  assign done = done_r;
  assign q    = q_r;
  assign ge   = (rem_r >= d_r);

  always_comb begin
    st_nxt   = st_r;
    mag_nxt  = mag_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    unique case (st_r)
      mi4_pkg::DV_IDLE: begin
        if (start) begin
          mag_nxt = cof[mi4_pkg::COF_W-1] ? mi4_pkg::COF_W'(-cof) : mi4_pkg::COF_W'(cof);
          den_nxt = den_abs;
          st_nxt  = mi4_pkg::DV_PREP;
        end
      end
      mi4_pkg::DV_PREP: begin
        rem_nxt = (mi4_pkg::DIV_W'(mag_r) << mi4_pkg::DSH) + mi4_pkg::DIV_W'(den_r);
        d_nxt   = mi4_pkg::DIV_W'({den_r, 1'b0}) << (mi4_pkg::QW - 1);
        q_nxt   = '0;
        cnt_nxt = mi4_pkg::QCNT_W'(mi4_pkg::QW - 1);
        st_nxt  = mi4_pkg::DV_RUN;
      end
      mi4_pkg::DV_RUN: begin
        rem_nxt = ge ? rem_r - d_r : rem_r;
        q_nxt   = {q_r[mi4_pkg::QW-2:0], ge};
        d_nxt   = d_r >> 1;
        if (cnt_r == '0) begin
          done_nxt = 1'b1;
          st_nxt   = mi4_pkg::DV_IDLE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: st_nxt = mi4_pkg::DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= mi4_pkg::DV_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

// ===== hw/rtl/matrix_4x4_inverse.sv =====
// ----------------------------------------------------------------------------
// matrix_4x4_inverse: 4x4 matrix inverse by cofactors in Q16.16
// Microcoded sequencer driving one limb-serial multiplier and one divider.
// ----------------------------------------------------------------------------
// Elements are written one word at a time at their row-major position and may
// be written in any order; a word to position 15 starts a run on the stored
// matrix, during which no input word is taken. A run forms 24 pair products,
// 16 cofactors and the determinant on a single 33 x 32 bit multiplier, one
// 32-bit limb per cycle, then divides each cofactor with a one-bit-per-cycle
// divider of 34 steps. When the determinant is zero the division is skipped
// and the stored elements are returned with the singular flag. Results carry
// their index, a saturation flag and tlast on the sixteenth word; after a
// regular run the store holds the inverse.
module matrix_4x4_inverse (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // elem_index[3:0], elem_value[35:4]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_index[3:0], out_value[35:4]
  output logic [1:0]  out_tuser,  // singular[0], saturated[1]
  output logic        out_tlast
);

  mi4_pkg::st_t                  st_r, st_nxt;
  logic [mi4_pkg::STEP_W-1:0]    step_r, step_nxt;
  logic [mi4_pkg::LIMB_CW-1:0]   limb_r, limb_nxt;
  mi4_pkg::cw_t                  cw;

  logic [mi4_pkg::ELEM_W-1:0]    store_mem [16];
  logic [15:0]                   store_vld_r;
  logic [mi4_pkg::ELEM_W-1:0]    store_q_r;
  logic [mi4_pkg::IDX_W-1:0]     store_raddr;
  logic                          store_we;
  logic [mi4_pkg::IDX_W-1:0]     store_waddr;
  logic [mi4_pkg::ELEM_W-1:0]    store_wdata;

  logic [mi4_pkg::SCR_W-1:0]     scr_mem [mi4_pkg::SCR_DEPTH];
  logic [mi4_pkg::SCR_W-1:0]     scr_q_r;
  logic                          scr_we;

  logic [mi4_pkg::ACC_W-1:0]     det_r, det_nxt;
  logic [mi4_pkg::DET_W-1:0]     det_abs_r, det_abs_nxt;
  logic                          neg_r, neg_nxt;
  logic [mi4_pkg::ELEM_W-1:0]    val_r, val_nxt;
  logic                          sat_r, sat_nxt;

  logic                          out_tvalid_r, out_tvalid_nxt;
  logic [39:0]                   out_tdata_r;
  logic [1:0]                    out_tuser_r;
  logic                          out_tlast_r;
  logic                          out_load;
  logic                          out_free;
  logic [mi4_pkg::ELEM_W-1:0]    out_val;
  logic                          out_sing;
  logic                          out_sat;

  logic                          accept;
  logic                          det_zero;
  mi4_pkg::mac_ctl_t             mac_ctl;
  logic [mi4_pkg::SCR_W-1:0]     mac_a;
  logic [mi4_pkg::ACC_W-1:0]     acc_nxt;
  logic                          div_start;
  logic                          div_done;
  logic [mi4_pkg::QW-1:0]        div_q;

  assign cw         = mi4_pkg::ucode(step_r);
  assign in_tready  = (st_r == mi4_pkg::S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign det_zero   = (det_r == '0);
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;
  assign mac_a      = cw.a_elem
                      ? {{(mi4_pkg::SCR_W - mi4_pkg::ELEM_W){store_q_r[mi4_pkg::ELEM_W-1]}},
                         store_q_r}
                      : scr_q_r;

  mi4_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mac_ctl),
    .a_val   (mac_a),
    .b_val   (store_q_r),
    .acc_nxt (acc_nxt)
  );

  mi4_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .cof     (scr_q_r[mi4_pkg::COF_W-1:0]),
    .den_abs (det_abs_r),
    .done    (div_done),
    .q       (div_q)
  );

  always_comb begin
    st_nxt      = st_r;
    step_nxt    = step_r;
    limb_nxt    = limb_r;
    det_nxt     = det_r;
    det_abs_nxt = det_abs_r;
    neg_nxt     = neg_r;
    val_nxt     = val_r;
    sat_nxt     = sat_r;
    mac_ctl     = '0;
    div_start   = 1'b0;
    scr_we      = 1'b0;
    out_load    = 1'b0;
    out_val     = store_q_r;
    out_sing    = 1'b1;
    out_sat     = 1'b0;
    store_raddr = (st_r == mi4_pkg::S_RDB || st_r == mi4_pkg::S_MUL) ? cw.eb : cw.ea;
    store_we    = accept;
    store_waddr = in_tdata[3:0];
    store_wdata = in_tdata[35:4];
    unique case (st_r)
      mi4_pkg::S_IDLE: begin
        if (accept && in_tdata[3:0] == mi4_pkg::IDX_LAST) begin
          step_nxt = '0;
          st_nxt   = mi4_pkg::S_RDA;
        end
      end
      mi4_pkg::S_RDA: begin
        unique case (cw.op)
          mi4_pkg::OP_MAC, mi4_pkg::OP_DIV: st_nxt = mi4_pkg::S_RDB;
          mi4_pkg::OP_RAW: st_nxt = mi4_pkg::S_OUT;
          mi4_pkg::OP_JZ: begin
            det_abs_nxt = det_r[mi4_pkg::ACC_W-1] ? mi4_pkg::DET_W'(-det_r)
                                                  : mi4_pkg::DET_W'(det_r);
            if (cw.done) begin
              st_nxt = mi4_pkg::S_IDLE;
            end else begin
              step_nxt = det_zero ? cw.target : step_r + 1'b1;
            end
          end
          default: st_nxt = mi4_pkg::S_IDLE;
        endcase
      end
      mi4_pkg::S_RDB: begin
        mac_ctl.load = 1'b1;
        mac_ctl.clr  = cw.clr;
        if (cw.op == mi4_pkg::OP_DIV) begin
          div_start = 1'b1;
          neg_nxt   = scr_q_r[mi4_pkg::COF_W-1] ^ det_r[mi4_pkg::ACC_W-1];
          st_nxt    = mi4_pkg::S_DIV;
        end else begin
          limb_nxt = '0;
          st_nxt   = mi4_pkg::S_MUL;
        end
      end
      mi4_pkg::S_MUL: begin
        mac_ctl.mul  = 1'b1;
        mac_ctl.limb = limb_r;
        mac_ctl.top  = (limb_r == cw.nl);
        mac_ctl.sub  = cw.sub;
        if (limb_r == cw.nl) begin
          st_nxt = mi4_pkg::S_TAIL;
        end else begin
          limb_nxt = limb_r + 1'b1;
        end
      end
      mi4_pkg::S_TAIL: begin
        scr_we = cw.wr;
        if (cw.wr_det) det_nxt = acc_nxt;
        step_nxt = step_r + 1'b1;
        st_nxt   = mi4_pkg::S_RDA;
      end
      mi4_pkg::S_DIV: begin
        if (div_done) begin
          if (neg_r) begin
            sat_nxt = (div_q > mi4_pkg::QW'(mi4_pkg::VAL_MIN));
            val_nxt = sat_nxt ? mi4_pkg::VAL_MIN : mi4_pkg::ELEM_W'(-div_q[31:0]);
          end else begin
            sat_nxt = (div_q > mi4_pkg::QW'(mi4_pkg::VAL_MAX));
            val_nxt = sat_nxt ? mi4_pkg::VAL_MAX : div_q[31:0];
          end
          st_nxt = mi4_pkg::S_OUT;
        end
      end
      mi4_pkg::S_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (cw.op == mi4_pkg::OP_DIV) begin
            out_val     = val_r;
            out_sing    = 1'b0;
            out_sat     = sat_r;
            store_we    = 1'b1;
            store_waddr = cw.k;
            store_wdata = val_r;
          end
          if (cw.done) begin
            st_nxt = mi4_pkg::S_IDLE;
          end else begin
            step_nxt = step_r + 1'b1;
            st_nxt   = mi4_pkg::S_RDA;
          end
        end
      end
      default: st_nxt = mi4_pkg::S_IDLE;
    endcase
    out_tvalid_nxt = (out_tvalid_r && !out_tready) || out_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= mi4_pkg::S_IDLE;
      step_r       <= '0;
      limb_r       <= '0;
      store_vld_r  <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      step_r       <= step_nxt;
      limb_r       <= limb_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (store_we) store_vld_r[store_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    det_r     <= det_nxt;
    det_abs_r <= det_abs_nxt;
    neg_r     <= neg_nxt;
    val_r     <= val_nxt;
    sat_r     <= sat_nxt;
    if (out_load) begin
      out_tdata_r <= {4'd0, out_val, cw.k};
      out_tuser_r <= {out_sat, out_sing};
      out_tlast_r <= cw.last;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) store_mem[store_waddr] <= store_wdata;
    store_q_r <= store_vld_r[store_raddr] ? store_mem[store_raddr] : '0;
  end

  always_ff @(posedge clk) begin
    if (scr_we) scr_mem[cw.dst] <= acc_nxt[mi4_pkg::SCR_W-1:0];
    scr_q_r <= scr_mem[cw.a_addr];
  end

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> st_r == mi4_pkg::S_DIV)
    else $error("divider finished outside the divide step");

  a_limb_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == mi4_pkg::S_MUL |-> limb_r <= cw.nl)
    else $error("limb counter ran past the operand width");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_tuser_r[0] |-> !out_tuser_r[1])
    else $error("singular word flagged as saturated");

endmodule
